// ===== sv/mipsx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipsx_pkg
// Shared types, opcodes and constants of the MIPS subset execute block.
// ----------------------------------------------------------------------------
package mipsx_pkg;

  // Start of the text segment and the region mask used by J and JAL.
  localparam logic [31:0] TEXT_BASE   = 32'h0040_0000;
  localparam logic [31:0] REGION_MASK = 32'hf000_0000;

  localparam int REG_COUNT  = 32;
  localparam int REG_AW     = 5;
  localparam int CNT_W      = 17;

  // Item kinds on the command channel.
  localparam logic OP_INSTR = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Memory request codes.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  // Configuration register addresses (byte addresses).
  localparam logic [1:0] ADDR_TEXT_COUNT = 2'd0;

  // Primary opcodes.
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTIU   = 6'h0b;
  localparam logic [5:0] OPC_ANDI    = 6'h0c;
  localparam logic [5:0] OPC_ORI     = 6'h0d;
  localparam logic [5:0] OPC_LUI     = 6'h0f;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_SW      = 6'h2b;

  // Function codes of the SPECIAL opcode.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // One item on the command channel.
  typedef struct packed {
    logic        op;
    logic [31:0] instr_word;
    logic [31:0] load_data;
  } cmd_t;

  // One item on the result channel.
  typedef struct packed {
    logic [31:0] pc_now;
    logic [1:0]  mem_cmd;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        reg_write_en;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        running;
    logic        error_code;
  } res_t;

endpackage

// ===== sv/mipsx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipsx_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mipsx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port returns the old contents on a same-address collision.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/mips_subset_instruction_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute
// Executes a MIPS-32 integer subset one item at a time, with the register
// file held in two synchronous RAM copies.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel carries either the instruction word at the current PC
//   or the data returned for a pending LW. The res channel carries one item
//   per command: the PC after the step, the memory request, the register
//   write and the run and error status. The APB port holds the count of
//   instruction words in the text segment; write it while the block is idle.
//   At a command transfer the register file RAM is read and the command is
//   captured in the execute stage; execute then loads the result register,
//   from which the result transfer is made. A new command transfer is taken
//   every cycle unless the execute stage is full and the result stalls; a
//   register written by one instruction and read by the next is forwarded
//   around the RAM from the last write-back.
//   Reset clears the PC to the text base, marks every register as zero
//   through per-entry valid flags, sets the run flag and clears the text
//   count. While the receiver stalls, the result register holds, the execute
//   stage holds once it is full, and then cmd_stall rises.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute (
  input  logic              clk,
  input  logic              rst,
  // Command channel
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  mipsx_pkg::cmd_t   cmd,
  // Result channel
  output logic              res_valid,
  input  logic              res_stall,
  output mipsx_pkg::res_t   res,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Architectural state kept in flops.
  logic [31:0]                    pc;
  logic                           run_flag;
  logic                           load_pending;
  logic [mipsx_pkg::REG_AW-1:0]   load_dest;
  logic [mipsx_pkg::CNT_W-1:0]    text_count;
  logic [mipsx_pkg::REG_COUNT-1:0] reg_vld;

  // Execute stage holding register.
  logic        s1_valid;
  mipsx_pkg::cmd_t s1_cmd;
  logic        s1_rs_vld;
  logic        s1_rt_vld;
  logic        s1_fire;
  logic        cmd_take;

  // Last register write-back, used to bypass the RAM.
  logic                         wb_en;
  logic [mipsx_pkg::REG_AW-1:0] wb_idx;
  logic [31:0]                  wb_val;

  // RAM ports.
  logic [31:0] rs_ram;
  logic [31:0] rt_ram;
  logic [mipsx_pkg::REG_AW-1:0] rs_in;
  logic [mipsx_pkg::REG_AW-1:0] rt_in;

  // Execute signals.
  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [15:0] imm;
  logic [31:0] imm_sx;
  logic [31:0] vs;
  logic [31:0] vt;
  logic [31:0] pc4;
  logic [32:0] text_end;
  logic        in_range;

  logic [31:0] pc_next;
  logic        run_next;
  logic        lp_next;
  logic [4:0]  ld_next;
  logic [1:0]  x_cmd;
  logic [31:0] x_addr;
  logic [31:0] x_wdata;
  logic [4:0]  x_widx;
  logic [31:0] x_wval;
  logic        x_err;
  logic        x_wen;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  assign prdata = (paddr == mipsx_pkg::ADDR_TEXT_COUNT)
                ? {{(32 - mipsx_pkg::CNT_W){1'b0}}, text_count} : 32'd0;

  // Handshake: the execute stage advances unless the result register is
  // full and stalled; a command enters whenever the execute stage frees up.
  assign s1_fire   = s1_valid && !(res_valid && res_stall);
  assign cmd_stall = s1_valid && !s1_fire;
  assign cmd_take  = cmd_valid && !cmd_stall;

  assign rs_in = cmd.instr_word[25:21];
  assign rt_in = cmd.instr_word[20:16];

  // Two copies of the register file give two read ports.
  mipsx_ram #(.WIDTH(32), .DEPTH(mipsx_pkg::REG_COUNT)) u_ram_rs (
    .clk     (clk),
    .wr_en   (s1_fire && x_wen),
    .wr_addr (x_widx),
    .wr_data (x_wval),
    .rd_en   (cmd_take),
    .rd_addr (rs_in),
    .rd_data (rs_ram)
  );

  mipsx_ram #(.WIDTH(32), .DEPTH(mipsx_pkg::REG_COUNT)) u_ram_rt (
    .clk     (clk),
    .wr_en   (s1_fire && x_wen),
    .wr_addr (x_widx),
    .wr_data (x_wval),
    .rd_en   (cmd_take),
    .rd_addr (rt_in),
    .rd_data (rt_ram)
  );

  // Capture the command together with the valid flags of its operands.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_cmd    <= cmd;
      s1_rs_vld <= reg_vld[rs_in];
      s1_rt_vld <= reg_vld[rt_in];
    end
  end

  // Instruction fields.
  assign opc    = s1_cmd.instr_word[31:26];
  assign rs     = s1_cmd.instr_word[25:21];
  assign rt     = s1_cmd.instr_word[20:16];
  assign rd     = s1_cmd.instr_word[15:11];
  assign sh     = s1_cmd.instr_word[10:6];
  assign fn     = s1_cmd.instr_word[5:0];
  assign imm    = s1_cmd.instr_word[15:0];
  assign imm_sx = {{16{imm[15]}}, imm};
  assign pc4    = pc + 32'd4;

  // Operands: bypass the last write-back, unwritten entries read as zero.
  assign vs = (wb_en && wb_idx == rs) ? wb_val : (s1_rs_vld ? rs_ram : 32'd0);
  assign vt = (wb_en && wb_idx == rt) ? wb_val : (s1_rt_vld ? rt_ram : 32'd0);

  // Text range check.
  assign text_end = {1'b0, mipsx_pkg::TEXT_BASE}
                  + {14'd0, text_count, 2'b00};
  assign in_range = (pc >= mipsx_pkg::TEXT_BASE) && ({1'b0, pc} < text_end);

  // Execute one item.
  always_comb begin
    pc_next  = pc;
    run_next = run_flag;
    lp_next  = load_pending;
    ld_next  = load_dest;
    x_cmd    = mipsx_pkg::MEM_NONE;
    x_addr   = 32'd0;
    x_wdata  = 32'd0;
    x_widx   = 5'd0;
    x_wval   = 32'd0;
    x_err    = 1'b0;
    if (!run_flag) begin
      // Halted: the item is ignored.
    end else if (s1_cmd.op == mipsx_pkg::OP_LOAD) begin
      if (load_pending) begin
        lp_next = 1'b0;
        ld_next = 5'd0;
        x_widx  = load_dest;
        x_wval  = s1_cmd.load_data;
      end
    end else if (load_pending) begin
      // An instruction while a load is outstanding is dropped.
    end else if (!in_range) begin
      run_next = 1'b0;
    end else begin
      pc_next = pc4;
      case (opc)
        mipsx_pkg::OPC_ADDIU: begin
          x_widx = rt;
          x_wval = vs + imm_sx;
        end
        mipsx_pkg::OPC_ANDI: begin
          x_widx = rt;
          x_wval = vs & {16'd0, imm};
        end
        mipsx_pkg::OPC_ORI: begin
          x_widx = rt;
          x_wval = vs | {16'd0, imm};
        end
        mipsx_pkg::OPC_LUI: begin
          x_widx = rt;
          x_wval = {imm, 16'd0};
        end
        mipsx_pkg::OPC_SLTIU: begin
          x_widx = rt;
          x_wval = {31'd0, vs < imm_sx};
        end
        mipsx_pkg::OPC_LW: begin
          x_cmd   = mipsx_pkg::MEM_READ;
          x_addr  = vs + imm_sx;
          lp_next = 1'b1;
          ld_next = rt;
        end
        mipsx_pkg::OPC_SW: begin
          x_cmd   = mipsx_pkg::MEM_WRITE;
          x_addr  = vs + imm_sx;
          x_wdata = vt;
        end
        mipsx_pkg::OPC_BEQ: begin
          if (vs == vt) begin
            pc_next = pc4 + {imm_sx[29:0], 2'b00};
          end
        end
        mipsx_pkg::OPC_BNE: begin
          if (vs != vt) begin
            pc_next = pc4 + {imm_sx[29:0], 2'b00};
          end
        end
        mipsx_pkg::OPC_J: begin
          pc_next = (pc4 & mipsx_pkg::REGION_MASK)
                  | {4'd0, s1_cmd.instr_word[25:0], 2'b00};
        end
        mipsx_pkg::OPC_JAL: begin
          x_widx  = 5'd31;
          x_wval  = pc + 32'd8;
          pc_next = (pc4 & mipsx_pkg::REGION_MASK)
                  | {4'd0, s1_cmd.instr_word[25:0], 2'b00};
        end
        mipsx_pkg::OPC_SPECIAL: begin
          case (fn)
            mipsx_pkg::FN_ADDU: begin
              x_widx = rd;
              x_wval = vs + vt;
            end
            mipsx_pkg::FN_AND: begin
              x_widx = rd;
              x_wval = vs & vt;
            end
            mipsx_pkg::FN_NOR: begin
              x_widx = rd;
              x_wval = ~(vs | vt);
            end
            mipsx_pkg::FN_OR: begin
              x_widx = rd;
              x_wval = vs | vt;
            end
            mipsx_pkg::FN_SLTU: begin
              x_widx = rd;
              x_wval = {31'd0, vs < vt};
            end
            mipsx_pkg::FN_SLL: begin
              x_widx = rd;
              x_wval = vt << sh;
            end
            mipsx_pkg::FN_SRL: begin
              x_widx = rd;
              x_wval = vt >> sh;
            end
            mipsx_pkg::FN_SUBU: begin
              x_widx = rd;
              x_wval = vs - vt;
            end
            mipsx_pkg::FN_JR: begin
              pc_next = vs;
            end
            default: begin
              pc_next  = pc;
              run_next = 1'b0;
              x_err    = 1'b1;
            end
          endcase
        end
        default: begin
          pc_next  = pc;
          run_next = 1'b0;
          x_err    = 1'b1;
        end
      endcase
    end
  end

  // Writes to r0 are discarded.
  assign x_wen = (x_widx != 5'd0);

  // Control state and execute-stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= mipsx_pkg::TEXT_BASE;
      run_flag     <= 1'b1;
      load_pending <= 1'b0;
      load_dest    <= 5'd0;
      reg_vld      <= '0;
      wb_en        <= 1'b0;
      s1_valid     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cmd_take) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        res_valid    <= 1'b1;
        pc           <= pc_next;
        run_flag     <= run_next;
        load_pending <= lp_next;
        load_dest    <= ld_next;
        if (x_wen) begin
          reg_vld[x_widx] <= 1'b1;
          wb_en           <= 1'b1;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Text count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_count <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == mipsx_pkg::ADDR_TEXT_COUNT) begin
      text_count <= pwdata[mipsx_pkg::CNT_W-1:0];
    end
  end

  // Write-back bypass data and the result register.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (x_wen) begin
        wb_idx <= x_widx;
        wb_val <= x_wval;
      end
      res.pc_now          <= pc_next;
      res.mem_cmd         <= x_cmd;
      res.mem_addr        <= x_addr;
      res.mem_wdata       <= x_wdata;
      res.reg_write_en    <= x_wen;
      res.reg_write_index <= x_wen ? x_widx : 5'd0;
      res.reg_write_value <= x_wen ? x_wval : 32'd0;
      res.running         <= run_next;
      res.error_code      <= x_err;
    end
  end

  // A halt is permanent until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    !run_flag |=> !run_flag)
    else $error("run flag set again after halt");

  // An error result always reports the block halted.
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_code |-> !res.running)
    else $error("error result while still running");

  // r0 is never reported as written, nor marked as written.
  a_no_r0: assert property (@(posedge clk) disable iff (rst)
    !reg_vld[0] && (!(res_valid && res.reg_write_en) || res.reg_write_index != 5'd0))
    else $error("write to r0 reported");

  // A full, blocked execute stage backpressures the command channel.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && res_stall |-> cmd_stall)
    else $error("command taken while execute stage is blocked");

  // A read request always leaves a load outstanding.
  a_load_pending: assert property (@(posedge clk) disable iff (rst)
    s1_fire && x_cmd == mipsx_pkg::MEM_READ |=> load_pending)
    else $error("load issued without pending flag");

endmodule

// ===== sim/tb_mips_subset_instruction_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_subset_instruction_execute
// Self-checking bench for the MIPS subset execute block. A short directed
// program hits the immediate rules, wrap-around, r0 writes, ignored items and
// every operation but AND and OR. Random programs then run under several
// text counts, with the branch and jump targets kept inside the text range.
// The run ends with one halt and a few items sent to the halted core. Every
// result transfer is compared with a step-by-step software copy of the core.
// ----------------------------------------------------------------------------
module tb_mips_subset_instruction_execute;
  import mipsx_pkg::*;

  // Two copies of the core state: one steers the program generator, the
  // other predicts the results as the block takes each transfer.
  localparam int MDL_GEN = 0;
  localparam int MDL_CHK = 1;

  // Ways to end the run.
  localparam int HALT_PAST_END   = 0;
  localparam int HALT_BAD_CODE   = 1;
  localparam int HALT_BELOW_BASE = 2;

  localparam int STUCK_LIMIT = 1000;
  localparam int RX_HOLD     = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = ADDR_TEXT_COUNT;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Core state copies.
  logic [31:0] pc_st [2];
  logic [31:0] rf [2][32];
  logic        run_st [2];
  logic        ld_pend [2];
  logic [4:0]  ld_dest [2];
  logic [16:0] text_cnt [2];

  cmd_t items_to_send [$];
  res_t reports_due [$];

  int useful_sent = 0;
  int items_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int stuck = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  mips_subset_instruction_execute dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_core_copies();
    for (int s = 0; s < 2; s++) begin
      pc_st[s] = TEXT_BASE;
      for (int k = 0; k < 32; k++) rf[s][k] = '0;
      run_st[s] = 1'b1;
      ld_pend[s] = 1'b0;
      ld_dest[s] = '0;
      text_cnt[s] = '0;
    end
  endfunction

  // Executes one item on state copy s and returns the result it reports.
  function automatic res_t mips_step(int s, cmd_t c);
    res_t r;
    logic [31:0] iw, cur, vs, vt, simm, zimm, npc, wval;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic [32:0] text_end;
    logic        bad;
    r = '0;
    widx = '0;
    wval = '0;
    bad = 1'b0;
    iw = c.instr_word;
    cur = pc_st[s];
    text_end = {1'b0, TEXT_BASE} + {14'b0, text_cnt[s], 2'b00};
    if (!run_st[s]) begin
      r.pc_now = cur;
      return r;
    end
    if (c.op == OP_LOAD) begin
      // Load data counts only when a load is waiting for it.
      if (ld_pend[s]) begin
        ld_pend[s] = 1'b0;
        widx = ld_dest[s];
        wval = c.load_data;
        ld_dest[s] = '0;
      end
    end else if (!ld_pend[s]) begin
      if ({1'b0, cur} >= text_end || cur < TEXT_BASE) begin
        run_st[s] = 1'b0;
      end else begin
        opc = iw[31:26];
        rs = iw[25:21];
        rt = iw[20:16];
        rd = iw[15:11];
        sh = iw[10:6];
        fn = iw[5:0];
        simm = {{16{iw[15]}}, iw[15:0]};
        zimm = {16'b0, iw[15:0]};
        vs = rf[s][rs];
        vt = rf[s][rt];
        npc = cur + 32'd4;
        case (opc)
          OPC_ADDIU: begin widx = rt; wval = vs + simm; end
          OPC_ANDI:  begin widx = rt; wval = vs & zimm; end
          OPC_ORI:   begin widx = rt; wval = vs | zimm; end
          OPC_LUI:   begin widx = rt; wval = {iw[15:0], 16'b0}; end
          OPC_SLTIU: begin widx = rt; wval = (vs < simm) ? 32'd1 : 32'd0; end
          OPC_LW: begin
            r.mem_cmd = MEM_READ;
            r.mem_addr = vs + simm;
            ld_pend[s] = 1'b1;
            ld_dest[s] = rt;
          end
          OPC_SW: begin
            r.mem_cmd = MEM_WRITE;
            r.mem_addr = vs + simm;
            r.mem_wdata = vt;
          end
          OPC_BEQ: if (vs == vt) npc = cur + 32'd4 + (simm << 2);
          OPC_BNE: if (vs != vt) npc = cur + 32'd4 + (simm << 2);
          OPC_J: npc = ((cur + 32'd4) & REGION_MASK) | {4'b0, iw[25:0], 2'b00};
          OPC_JAL: begin
            widx = 5'd31;
            wval = cur + 32'd8;
            npc = ((cur + 32'd4) & REGION_MASK) | {4'b0, iw[25:0], 2'b00};
          end
          OPC_SPECIAL: begin
            case (fn)
              FN_ADDU: begin widx = rd; wval = vs + vt; end
              FN_AND:  begin widx = rd; wval = vs & vt; end
              FN_NOR:  begin widx = rd; wval = ~(vs | vt); end
              FN_OR:   begin widx = rd; wval = vs | vt; end
              FN_SLTU: begin widx = rd; wval = (vs < vt) ? 32'd1 : 32'd0; end
              FN_SLL:  begin widx = rd; wval = vt << sh; end
              FN_SRL:  begin widx = rd; wval = vt >> sh; end
              FN_SUBU: begin widx = rd; wval = vs - vt; end
              FN_JR:   npc = vs;
              default: bad = 1'b1;
            endcase
          end
          default: bad = 1'b1;
        endcase
        // An unknown code halts with no other effect.
        if (bad) begin
          run_st[s] = 1'b0;
          r.error_code = 1'b1;
          widx = '0;
        end else begin
          pc_st[s] = npc;
        end
      end
    end
    if (widx != '0) begin
      rf[s][widx] = wval;
      r.reg_write_en = 1'b1;
      r.reg_write_index = widx;
      r.reg_write_value = wval;
    end
    r.pc_now = pc_st[s];
    r.running = run_st[s];
    return r;
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {OPC_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  // Jump to word index idx of the text segment.
  function automatic logic [31:0] enc_j(logic [5:0] opc, int idx);
    return {opc, 26'((TEXT_BASE >> 2) + idx)};
  endfunction

  function automatic logic is_known(logic [31:0] w);
    case (w[31:26])
      OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDIU, OPC_SLTIU, OPC_ANDI, OPC_ORI,
      OPC_LUI, OPC_LW, OPC_SW: return 1'b1;
      OPC_SPECIAL: begin
        case (w[5:0])
          FN_SLL, FN_SRL, FN_JR, FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLTU:
            return 1'b1;
          default: return 1'b0;
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  // Queues one item and advances the generator's copy of the core.
  function automatic void send_item(logic op, logic [31:0] w, logic [31:0] d);
    cmd_t c;
    c.op = op;
    c.instr_word = w;
    c.load_data = d;
    if (run_st[MDL_GEN] && ((op == OP_LOAD) == ld_pend[MDL_GEN])) useful_sent++;
    void'(mips_step(MDL_GEN, c));
    items_to_send.push_back(c);
  endfunction

  // Half the time a small set of registers, so results feed the next item.
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 99) < 50) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  // One random item that keeps the program counter inside the text range.
  task automatic gen_random_item();
    int n, p, lo, hi, off, sel;
    logic [5:0] opc, fn;
    logic [4:0] rs, rt, rd, jr_reg;
    logic [31:0] w, v;
    logic found;
    n = int'(text_cnt[MDL_GEN]);
    p = int'((pc_st[MDL_GEN] - TEXT_BASE) >> 2);
    if (ld_pend[MDL_GEN]) begin
      if ($urandom_range(0, 99) < 88) send_item(OP_LOAD, $urandom, $urandom);
      else send_item(OP_INSTR, $urandom, $urandom);
      return;
    end
    if ($urandom_range(0, 99) < 4) begin
      send_item(OP_LOAD, $urandom, $urandom);
      return;
    end
    rs = pick_reg();
    rt = pick_reg();
    rd = pick_reg();
    opc = OPC_SPECIAL;
    fn = FN_SLL;
    sel = $urandom_range(0, 19);
    case (sel)
      0: opc = OPC_J;
      1: opc = OPC_JAL;
      2: opc = OPC_BEQ;
      3: opc = OPC_BNE;
      4: opc = OPC_ADDIU;
      5: opc = OPC_SLTIU;
      6: opc = OPC_ANDI;
      7: opc = OPC_ORI;
      8: opc = OPC_LUI;
      9: opc = OPC_LW;
      10: opc = OPC_SW;
      11: fn = FN_SLL;
      12: fn = FN_SRL;
      13: fn = FN_JR;
      14: fn = FN_ADDU;
      15: fn = FN_SUBU;
      16: fn = FN_AND;
      17: fn = FN_OR;
      18: fn = FN_NOR;
      default: fn = FN_SLTU;
    endcase
    // The last word of the text segment must jump back into it.
    if (p == n - 1) opc = $urandom_range(0, 1) ? OPC_J : OPC_JAL;
    // A register jump needs a register holding an aligned address in range.
    if (opc == OPC_SPECIAL && fn == FN_JR) begin
      found = 1'b0;
      jr_reg = '0;
      for (int k = 31; k > 0; k--) begin
        v = rf[MDL_GEN][k];
        if (!found && v[1:0] == 2'b00 && v >= TEXT_BASE &&
            ({1'b0, v} < {1'b0, TEXT_BASE} + {14'b0, text_cnt[MDL_GEN], 2'b00})) begin
          found = 1'b1;
          jr_reg = 5'(k);
        end
      end
      if (!found) opc = OPC_JAL;
      rs = jr_reg;
    end
    case (opc)
      OPC_J, OPC_JAL: w = enc_j(opc, $urandom_range(0, n - 1));
      OPC_BEQ, OPC_BNE: begin
        lo = -(p + 1);
        if (lo < -32768) lo = -32768;
        hi = n - 2 - p;
        if (hi > 32767) hi = 32767;
        off = lo + int'($urandom_range(0, hi - lo));
        if ($urandom_range(0, 1)) rt = rs;
        w = enc_i(opc, rs, rt, 16'(off));
      end
      OPC_SPECIAL: w = enc_r(rs, rt, rd, 5'($urandom), fn);
      default: w = enc_i(opc, rs, rt, 16'($urandom));
    endcase
    send_item(OP_INSTR, w, $urandom);
  endtask

  // Returns once every queued item has gone and every result has come.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || cmd_valid || reports_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_TEXT_COUNT;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes the text count, reads it back and updates both core copies.
  task automatic set_text_count(int count);
    logic [31:0] rd;
    apb_access(1'b1, 32'(count), rd);
    text_cnt[MDL_GEN] = 17'(count);
    text_cnt[MDL_CHK] = 17'(count);
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(count)) begin
      $display("%0t ns: text count readback expected %h, got %h", $time, 32'(count), rd);
      mismatches++;
    end
  endtask

  // Ends a program section at the text base with nothing in flight.
  task automatic return_to_base();
    if (ld_pend[MDL_GEN]) send_item(OP_LOAD, $urandom, $urandom);
    send_item(OP_INSTR, enc_j(OPC_J, 0), $urandom);
    wait_idle();
  endtask

  task automatic run_phase(int count, int items);
    int goal;
    set_text_count(count);
    goal = useful_sent + items;
    while (useful_sent < goal) gen_random_item();
    return_to_base();
  endtask

  // Sender: one transfer per accepted item, with random gaps outside a
  // stretch where it offers an item every cycle.
  always @(posedge clk) begin : drive
    logic gap;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        reports_due.push_back(mips_step(MDL_CHK, cmd));
        items_taken <= items_taken + 1;
      end
      if (!cmd_valid || !cmd_stall) begin
        gap = (items_taken < 300 || items_taken >= 450) && ($urandom_range(0, 99) < 18);
        if (items_to_send.size() != 0 && !gap) begin
          cmd <= items_to_send.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold that backs up the block, and a
  // stretch with no stalls at all.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= RX_HOLD;
      res_stall <= 1'b1;
    end else if (results_seen >= 300 && results_seen < 450) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < 18);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Each result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen <= results_seen + 1;
      if (reports_due.size() == 0) begin
        $display("%0t ns: result with none expected, got pc_now %h", $time, res.pc_now);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        check_field("pc_now", want.pc_now, res.pc_now);
        check_field("mem_cmd", 32'(want.mem_cmd), 32'(res.mem_cmd));
        check_field("mem_addr", want.mem_addr, res.mem_addr);
        check_field("mem_wdata", want.mem_wdata, res.mem_wdata);
        check_field("reg_write_en", 32'(want.reg_write_en), 32'(res.reg_write_en));
        check_field("reg_write_index", 32'(want.reg_write_index), 32'(res.reg_write_index));
        check_field("reg_write_value", want.reg_write_value, res.reg_write_value);
        check_field("running", 32'(want.running), 32'(res.running));
        check_field("error_code", 32'(want.error_code), 32'(res.error_code));
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck == STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int kind;
    logic [31:0] w;
    logic [31:0] rd;
    reset_core_copies();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Count after reset reads as zero.
    apb_access(1'b0, '0, rd);
    if (rd !== 32'd0) begin
      $display("%0t ns: text count after reset expected %h, got %h", $time, 32'd0, rd);
      mismatches++;
    end

    // Directed program over a text segment of 65536 words.
    set_text_count(65536);
    send_item(OP_INSTR, enc_i(OPC_LUI, 5'd0, 5'd1, 16'hffff), $urandom);
    send_item(OP_INSTR, enc_i(OPC_ORI, 5'd1, 5'd1, 16'hffff), $urandom);
    send_item(OP_INSTR, enc_i(OPC_ADDIU, 5'd0, 5'd2, 16'h8000), $urandom);
    send_item(OP_INSTR, enc_i(OPC_ANDI, 5'd1, 5'd3, 16'h8001), $urandom);
    send_item(OP_INSTR, enc_i(OPC_SLTIU, 5'd0, 5'd4, 16'hffff), $urandom);
    send_item(OP_INSTR, enc_r(5'd1, 5'd1, 5'd5, 5'd0, FN_ADDU), $urandom);
    send_item(OP_INSTR, enc_r(5'd0, 5'd4, 5'd6, 5'd0, FN_SUBU), $urandom);
    send_item(OP_INSTR, enc_r(5'd1, 5'd0, 5'd8, 5'd0, FN_NOR), $urandom);
    send_item(OP_INSTR, enc_r(5'd4, 5'd1, 5'd10, 5'd0, FN_SLTU), $urandom);
    send_item(OP_INSTR, enc_r(5'd0, 5'd1, 5'd11, 5'd31, FN_SLL), $urandom);
    send_item(OP_INSTR, enc_r(5'd0, 5'd1, 5'd12, 5'd31, FN_SRL), $urandom);
    // A write to r0 is dropped.
    send_item(OP_INSTR, enc_i(OPC_ADDIU, 5'd1, 5'd0, 16'h0005), $urandom);
    // Store address wraps past the top of memory.
    send_item(OP_INSTR, enc_i(OPC_SW, 5'd1, 5'd1, 16'h7fff), $urandom);
    // Load, an instruction while it waits, its data, then data with no load.
    send_item(OP_INSTR, enc_i(OPC_LW, 5'd0, 5'd13, 16'h8000), 32'h0);
    send_item(OP_INSTR, enc_r(5'd1, 5'd1, 5'd14, 5'd0, FN_ADDU), 32'h0);
    send_item(OP_LOAD, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_LOAD, 32'h0, 32'h0);
    send_item(OP_INSTR, enc_i(OPC_LW, 5'd2, 5'd0, 16'h0000), $urandom);
    send_item(OP_LOAD, $urandom, $urandom);
    // Branches taken forward, not taken, and taken backward.
    send_item(OP_INSTR, enc_i(OPC_BEQ, 5'd1, 5'd1, 16'h0002), $urandom);
    send_item(OP_INSTR, enc_i(OPC_BNE, 5'd1, 5'd1, 16'hfff6), $urandom);
    send_item(OP_INSTR, enc_i(OPC_BNE, 5'd1, 5'd0, 16'hfffb), $urandom);
    // Call and return through r31.
    send_item(OP_INSTR, enc_j(OPC_JAL, 100), $urandom);
    send_item(OP_INSTR, enc_r(5'd31, 5'd0, 5'd0, 5'd0, FN_JR), $urandom);
    return_to_base();

    // Random programs under several text counts.
    run_phase(1, 20);
    run_phase($urandom_range(2, 64), 260);
    run_phase($urandom_range(65, 65535), 260);
    run_phase(65536, 260);

    // One halt, then items that the halted core ignores.
    kind = $urandom_range(HALT_PAST_END, HALT_BELOW_BASE);
    case (kind)
      HALT_PAST_END: begin
        set_text_count(0);
        send_item(OP_INSTR, $urandom, $urandom);
      end
      HALT_BAD_CODE: begin
        if ($urandom_range(0, 1)) begin
          w = $urandom;
          while (is_known(w)) w = $urandom;
        end else begin
          w = {OPC_SPECIAL, 20'($urandom), 6'($urandom)};
          while (is_known(w)) w = {OPC_SPECIAL, 20'($urandom), 6'($urandom)};
        end
        send_item(OP_INSTR, w, $urandom);
      end
      default: begin
        send_item(OP_INSTR, enc_r(5'd0, 5'($urandom), 5'($urandom), 5'($urandom), FN_JR),
                  $urandom);
        send_item(OP_INSTR, $urandom, $urandom);
      end
    endcase
    repeat (4) send_item(1'($urandom), $urandom, $urandom);
    wait_idle();
    if (kind != HALT_PAST_END) set_text_count(0);

    repeat (8) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
